// ===== hw/rtl/dar_pkg.sv =====
// ----------------------------------------------------------------------------
// dar_pkg: shared types and constants for the device address registry
// Field widths, operation/status/event codes and the controller-datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package dar_pkg;

    localparam int FUNC_W   = 3;
    localparam int LONG_W   = 64;
    localparam int SHORT_W  = 16;
    localparam int SEQ_W    = 32;
    localparam int STATUS_W = 2;
    localparam int KIND_W   = 2;
    localparam int FILL_W   = 5;

    // stream payload widths (tdata padded to whole bytes)
    localparam int S_TDATA_W = 112;
    localparam int S_TUSER_W = FUNC_W;
    localparam int M_TDATA_W = 120;
    localparam int M_TUSER_W = STATUS_W + KIND_W;
    localparam int M_PAD_W   = M_TDATA_W - (LONG_W + SHORT_W + 1 + SEQ_W + FILL_W);

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_UPSERT     = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE     = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_HEARTBEAT  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_FIND_LONG  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_FIND_SHORT = 3'd4;

    // result status
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    // event kinds
    localparam logic [KIND_W-1:0] EVENT_NONE      = 2'd0;
    localparam logic [KIND_W-1:0] EVENT_ONLINE    = 2'd1;
    localparam logic [KIND_W-1:0] EVENT_OFFLINE   = 2'd2;
    localparam logic [KIND_W-1:0] EVENT_HEARTBEAT = 2'd3;

    typedef struct packed {
        logic [LONG_W-1:0]  long_addr;
        logic [SHORT_W-1:0] net_addr;
        logic               online;
        logic [SEQ_W-1:0]   seq;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic start;    // latch operands, restart scan
        logic scan;     // issue next table read
        logic resolve;  // search done: update table and result
        logic swap_rd;  // read last entry
        logic swap_wr;  // write last entry into the hole
        logic emit;     // move result into output register
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;
        logic miss;
        logic need_swap;
    } ctrl_sts_t;

endpackage

// ===== hw/rtl/dar_ctrl.sv =====
// ----------------------------------------------------------------------------
// dar_ctrl: operation sequencer
// One-hot state machine that steps an operation through search, optional
// swap-remove and result hand-off; owns both stream handshakes.
// ----------------------------------------------------------------------------
module dar_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  dar_pkg::ctrl_sts_t sts,
    output dar_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SCAN    = 5'b00010,
        ST_SWAP_RD = 5'b00100,
        ST_SWAP_WR = 5'b01000,
        ST_EMIT    = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        cmd         = '0;
        cmd.start   = (state_reg == ST_IDLE) && s_tvalid;
        cmd.scan    = (state_reg == ST_SCAN);
        cmd.resolve = (state_reg == ST_SCAN) && (sts.hit || sts.miss);
        cmd.swap_rd = (state_reg == ST_SWAP_RD);
        cmd.swap_wr = (state_reg == ST_SWAP_WR);
        cmd.emit    = (state_reg == ST_EMIT) && out_free;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (sts.hit || sts.miss) begin
                    state_next = sts.need_swap ? ST_SWAP_RD : ST_EMIT;
                end
            end
            ST_SWAP_RD: state_next = ST_SWAP_WR;
            ST_SWAP_WR: state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.emit) m_tvalid_next = 1'b1;
        else if (m_tready) m_tvalid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ===== hw/rtl/dar_datapath.sv =====
// ----------------------------------------------------------------------------
// dar_datapath: entry table, search pipeline and result registers
// One-write/one-read table memory with registered read, a sequential key
// compare, fill counter and the output payload register.
// ----------------------------------------------------------------------------
module dar_datapath #(
    parameter int ENTRIES = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [dar_pkg::FUNC_W-1:0]    in_func,
    input  logic [dar_pkg::LONG_W-1:0]    in_long,
    input  logic [dar_pkg::SHORT_W-1:0]   in_net,
    input  logic [dar_pkg::SEQ_W-1:0]     in_seq,
    input  dar_pkg::ctrl_cmd_t            cmd,
    output dar_pkg::ctrl_sts_t            sts,
    output logic [dar_pkg::STATUS_W-1:0]  out_status,
    output logic [dar_pkg::KIND_W-1:0]    out_kind,
    output dar_pkg::entry_t               out_entry,
    output logic [dar_pkg::FILL_W-1:0]    out_fill
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int FW    = dar_pkg::FILL_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRIES);

    dar_pkg::entry_t table_mem [ENTRIES];

    // operands
    logic [dar_pkg::FUNC_W-1:0]  op_func_reg;
    logic [dar_pkg::LONG_W-1:0]  op_long_reg;
    logic [dar_pkg::SHORT_W-1:0] op_net_reg;
    logic [dar_pkg::SEQ_W-1:0]   op_seq_reg;

    // search
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] scan_idx_reg;
    logic             rd_valid_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic [IDX_W-1:0] hole_idx_reg;
    dar_pkg::entry_t  rd_data_reg;

    // pending result and output register
    logic [dar_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [dar_pkg::KIND_W-1:0]   res_kind_reg, res_kind_next;
    dar_pkg::entry_t              res_entry_reg, res_entry_next;
    logic [dar_pkg::STATUS_W-1:0] m_status_reg;
    logic [dar_pkg::KIND_W-1:0]   m_kind_reg;
    dar_pkg::entry_t              m_entry_reg;
    logic [FW-1:0]                m_fill_reg;

    logic             use_long, use_short, match, scan_more;
    logic             rd_en, wr_en;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    dar_pkg::entry_t  wr_data;
    dar_pkg::entry_t  fresh;

    assign use_long  = (op_func_reg == dar_pkg::FUNC_UPSERT)
                    || (op_func_reg == dar_pkg::FUNC_HEARTBEAT)
                    || (op_func_reg == dar_pkg::FUNC_FIND_LONG);
    assign use_short = (op_func_reg == dar_pkg::FUNC_REMOVE)
                    || (op_func_reg == dar_pkg::FUNC_FIND_SHORT);
    assign match = rd_valid_reg
                && ((use_long && (rd_data_reg.long_addr == op_long_reg))
                 || (use_short && (rd_data_reg.net_addr == op_net_reg)));
    assign scan_more = (scan_idx_reg < count_reg);

    // first match wins: entries are compared in index order
    assign sts.hit  = match;
    assign sts.miss = !match && !rd_valid_reg && !scan_more;
    assign sts.need_swap = match && (op_func_reg == dar_pkg::FUNC_REMOVE)
        && (((CNT_W+1)'(cmp_idx_reg) + (CNT_W+1)'(1)) < (CNT_W+1)'(count_reg));

    assign rd_en   = (cmd.scan && scan_more) || cmd.swap_rd;
    assign rd_addr = cmd.swap_rd ? count_reg[IDX_W-1:0] : scan_idx_reg[IDX_W-1:0];

    // freshly registered entry for upsert
    always_comb begin
        fresh           = '0;
        fresh.long_addr = op_long_reg;
        fresh.net_addr  = op_net_reg;
        fresh.online    = 1'b1;
    end

    always_comb begin
        wr_en           = 1'b0;
        wr_addr         = cmp_idx_reg;
        wr_data         = fresh;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_kind_next   = res_kind_reg;
        res_entry_next  = res_entry_reg;
        if (cmd.resolve) begin
            res_status_next = dar_pkg::STATUS_NOT_FOUND;
            res_kind_next   = dar_pkg::EVENT_NONE;
            res_entry_next  = '0;
            case (op_func_reg)
                dar_pkg::FUNC_UPSERT: begin
                    if (match) begin
                        wr_en           = 1'b1;
                        res_status_next = dar_pkg::STATUS_OK;
                        res_kind_next   = dar_pkg::EVENT_ONLINE;
                        res_entry_next  = fresh;
                    end else if (count_reg >= CNT_FULL) begin
                        res_status_next = dar_pkg::STATUS_FULL;
                    end else begin
                        wr_en           = 1'b1;
                        wr_addr         = count_reg[IDX_W-1:0];
                        count_next      = count_reg + CNT_W'(1);
                        res_status_next = dar_pkg::STATUS_OK;
                        res_kind_next   = dar_pkg::EVENT_ONLINE;
                        res_entry_next  = fresh;
                    end
                end
                dar_pkg::FUNC_REMOVE: begin
                    if (match) begin
                        count_next      = count_reg - CNT_W'(1);
                        res_status_next = dar_pkg::STATUS_OK;
                        res_kind_next   = dar_pkg::EVENT_OFFLINE;
                        res_entry_next  = rd_data_reg;
                    end
                end
                dar_pkg::FUNC_HEARTBEAT: begin
                    if (match) begin
                        wr_en           = 1'b1;
                        wr_data         = rd_data_reg;
                        wr_data.online  = 1'b1;
                        wr_data.seq     = op_seq_reg;
                        res_status_next = dar_pkg::STATUS_OK;
                        res_kind_next   = dar_pkg::EVENT_HEARTBEAT;
                        res_entry_next  = wr_data;
                    end
                end
                dar_pkg::FUNC_FIND_LONG, dar_pkg::FUNC_FIND_SHORT: begin
                    if (match) begin
                        res_status_next = dar_pkg::STATUS_OK;
                        res_entry_next  = rd_data_reg;
                    end
                end
                default: ;
            endcase
        end else if (cmd.swap_wr) begin
            // move the last entry into the removed slot
            wr_en   = 1'b1;
            wr_addr = hole_idx_reg;
            wr_data = rd_data_reg;
        end
    end

    // table memory
    always_ff @(posedge aclk) begin
        if (wr_en) table_mem[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= table_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
            scan_idx_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (cmd.start) begin
                scan_idx_reg <= '0;
                rd_valid_reg <= 1'b0;
            end else if (cmd.scan) begin
                rd_valid_reg <= scan_more;
                if (scan_more) scan_idx_reg <= scan_idx_reg + CNT_W'(1);
            end else begin
                rd_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_func_reg <= in_func;
            op_long_reg <= in_long;
            op_net_reg  <= in_net;
            op_seq_reg  <= in_seq;
        end
        if (cmd.scan) cmp_idx_reg <= scan_idx_reg[IDX_W-1:0];
        if (cmd.resolve) hole_idx_reg <= cmp_idx_reg;
        res_status_reg <= res_status_next;
        res_kind_reg   <= res_kind_next;
        res_entry_reg  <= res_entry_next;
        if (cmd.emit) begin
            m_status_reg <= res_status_reg;
            m_kind_reg   <= res_kind_reg;
            m_entry_reg  <= res_entry_reg;
            m_fill_reg   <= FW'(count_reg);
        end
    end

    assign out_status = m_status_reg;
    assign out_kind   = m_kind_reg;
    assign out_entry  = m_entry_reg;
    assign out_fill   = m_fill_reg;

endmodule

// ===== hw/rtl/device_address_registry_unit.sv =====
// ----------------------------------------------------------------------------
// device_address_registry_unit: node table keyed by 64-bit long address
// Upsert, remove-by-short (swap with last), heartbeat and two lookups over a
// table of up to ENTRIES nodes, one result transfer per input transfer.
// ----------------------------------------------------------------------------
// The block handles one operation at a time. An operation is taken when the
// unit is idle. The table memory is then searched one entry per cycle in
// index order, with a registered read and the compare in the cycle after
// the read, so the first match wins. A remove that leaves a hole below the
// last entry adds a move: the last entry is read, then written into the hole.
// With a full table of 16 entries the slowest operations are a miss and a
// remove of entry 14, which needs the move. The single read port of the
// table memory sets the search time. The finished result sits in an output
// register, so the next operation can be taken while the sink still holds the
// result off. That next operation then waits in its last step until the
// output register is free. Table contents are undefined after reset. Of the
// table state only the fill count is cleared, and entries at or beyond it
// are never searched. Unused operation codes return "not found" after a
// scan that never matches.
// ----------------------------------------------------------------------------
module device_address_registry_unit #(
    parameter int ENTRIES = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // operation input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [63:0] long_addr, [79:64] net_addr, [111:80] beat_seq
    input  logic [dar_pkg::S_TDATA_W-1:0]   s_tdata,
    // [2:0] func
    input  logic [dar_pkg::S_TUSER_W-1:0]   s_tuser,
    // result output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [63:0] entry_long, [79:64] entry_short, [80] entry_online,
    // [112:81] entry_seq, [117:113] fill, [119:118] zero
    output logic [dar_pkg::M_TDATA_W-1:0]   m_tdata,
    // [1:0] status, [3:2] event_kind
    output logic [dar_pkg::M_TUSER_W-1:0]   m_tuser
);

    localparam int LW = dar_pkg::LONG_W;
    localparam int SW = dar_pkg::SHORT_W;
    localparam int QW = dar_pkg::SEQ_W;

    dar_pkg::ctrl_cmd_t cmd;
    dar_pkg::ctrl_sts_t sts;

    logic [dar_pkg::STATUS_W-1:0] out_status;
    logic [dar_pkg::KIND_W-1:0]   out_kind;
    dar_pkg::entry_t              out_entry;
    logic [dar_pkg::FILL_W-1:0]   out_fill;

    // sequencer: handshakes and per-operation steps
    dar_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // table memory, search compare and result registers
    dar_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_func    (s_tuser),
        .in_long    (s_tdata[LW-1:0]),
        .in_net     (s_tdata[LW+SW-1:LW]),
        .in_seq     (s_tdata[LW+SW+QW-1:LW+SW]),
        .cmd        (cmd),
        .sts        (sts),
        .out_status (out_status),
        .out_kind   (out_kind),
        .out_entry  (out_entry),
        .out_fill   (out_fill)
    );

    assign m_tdata = {{dar_pkg::M_PAD_W{1'b0}}, out_fill, out_entry.seq,
                      out_entry.online, out_entry.net_addr, out_entry.long_addr};
    assign m_tuser = {out_kind, out_status};

endmodule

// ===== bench/device_address_registry_unit_tb.sv =====
// ----------------------------------------------------------------------------
// device_address_registry_unit_tb: self-checking bench for the node registry
// A short table of directed operations (empty table, extremes, full table,
// swap-with-last removal, unused codes), then about 1300 random operations
// biased toward keys already in the table. Every result transfer is checked,
// in order, against the typed result of its row or an in-bench predictor.
// Both stream sides idle at random; the sink also holds off for long stretches.
// ----------------------------------------------------------------------------
module device_address_registry_unit_tb;
    import dar_pkg::*;

    localparam int ENTRIES      = 16;
    localparam int RANDOM_OPS   = 1320;
    localparam int HOLD_CYCLES  = 400;   // long sink hold-off, fills the block
    localparam int TAIL_CYCLES  = 40;    // outlasts the slowest operation
    // ~1350 ops with sender gaps, slow sink and hold-offs; keep a wide margin
    localparam int CYCLE_LIMIT  = 600000;

    // func codes the block does not implement
    localparam logic [FUNC_W-1:0] FUNC_RSVD_LO  = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_RSVD_MID = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_RSVD_HI  = 3'd7;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [LONG_W-1:0]  long_addr;
        logic [SHORT_W-1:0] net_addr;
        logic [SEQ_W-1:0]   beat_seq;
    } op_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KIND_W-1:0]   kind;
        logic [LONG_W-1:0]   entry_long;
        logic [SHORT_W-1:0]  entry_short;
        logic                entry_online;
        logic [SEQ_W-1:0]    entry_seq;
        logic [FILL_W-1:0]   fill;
        logic [M_PAD_W-1:0]  pad;
    } reply_t;

    // one directed row: typed rows carry their result, the rest use the predictor
    typedef struct packed {
        op_t    op;
        logic   typed;
        reply_t want;
    } row_t;

    typedef enum logic [1:0] {
        SINK_OPEN,      // always ready
        SINK_COIN,      // ready half the time
        SINK_THIRD,     // ready one cycle in three
        SINK_RARE_STALL // stalls about one cycle in eight
    } sink_mode_t;

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // predictor copy of the node table
    logic [LONG_W-1:0]  node_long   [ENTRIES];
    logic [SHORT_W-1:0] node_short  [ENTRIES];
    logic               node_online [ENTRIES];
    logic [SEQ_W-1:0]   node_seq    [ENTRIES];
    int                 node_count = 0;

    reply_t queued_replies[$];     // results owed by the block, oldest first
    int     mismatch_cnt = 0;
    int     cycle_cnt    = 0;
    int     burst_left   = 0;
    logic   hold_req     = 1'b0;   // sender asks the sink for a long hold-off

    always #5 aclk = ~aclk;

    device_address_registry_unit #(.ENTRIES(ENTRIES)) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [63:0] long_addr, [79:64] net_addr, [111:80] beat_seq
        .s_tuser  (s_tuser),   // [2:0] func
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [63:0] long, [79:64] short, [80] online,
                               // [112:81] seq, [117:113] fill, [119:118] zero
        .m_tuser  (m_tuser)    // [1:0] status, [3:2] event_kind
    );

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic reply_t mk_reply(input logic [STATUS_W-1:0] status,
                                        input logic [KIND_W-1:0] kind,
                                        input logic [LONG_W-1:0] l,
                                        input logic [SHORT_W-1:0] s,
                                        input logic on,
                                        input logic [SEQ_W-1:0] sq,
                                        input logic [FILL_W-1:0] fill);
        reply_t r;
        r = '0;
        r.status       = status;
        r.kind         = kind;
        r.entry_long   = l;
        r.entry_short  = s;
        r.entry_online = on;
        r.entry_seq    = sq;
        r.fill         = fill;
        return r;
    endfunction

    // entry contents as they stand now; fill is patched in by the caller
    function automatic reply_t entry_reply(input int idx, input logic [KIND_W-1:0] kind);
        return mk_reply(STATUS_OK, kind, node_long[idx], node_short[idx],
                        node_online[idx], node_seq[idx], '0);
    endfunction

    function automatic reply_t apply_registry_op(input op_t op);
        reply_t r;
        int     hit;
        int     last;
        r = mk_reply(STATUS_NOT_FOUND, EVENT_NONE, '0, '0, 1'b0, '0, '0);
        hit = -1;
        // linear scan, first match wins
        for (int i = 0; i < node_count; i++) begin
            if (hit < 0) begin
                case (op.func)
                    FUNC_UPSERT, FUNC_HEARTBEAT, FUNC_FIND_LONG:
                        if (node_long[i] == op.long_addr) hit = i;
                    FUNC_REMOVE, FUNC_FIND_SHORT:
                        if (node_short[i] == op.net_addr) hit = i;
                    default: ;
                endcase
            end
        end
        case (op.func)
            FUNC_UPSERT: begin
                if (hit < 0 && node_count >= ENTRIES) begin
                    r.status = STATUS_FULL;
                end else begin
                    if (hit < 0) begin
                        hit = node_count;
                        node_count++;
                        node_long[hit] = op.long_addr;
                    end
                    // known key: short replaced, back online, sequence cleared
                    node_short[hit]  = op.net_addr;
                    node_online[hit] = 1'b1;
                    node_seq[hit]    = '0;
                    r = entry_reply(hit, EVENT_ONLINE);
                end
            end
            FUNC_REMOVE: begin
                if (hit >= 0) begin
                    r = entry_reply(hit, EVENT_OFFLINE);   // contents before removal
                    last = node_count - 1;
                    if (hit < last) begin
                        node_long[hit]   = node_long[last];
                        node_short[hit]  = node_short[last];
                        node_online[hit] = node_online[last];
                        node_seq[hit]    = node_seq[last];
                    end
                    node_count--;
                end
            end
            FUNC_HEARTBEAT: begin
                if (hit >= 0) begin
                    node_online[hit] = 1'b1;
                    node_seq[hit]    = op.beat_seq;
                    r = entry_reply(hit, EVENT_HEARTBEAT);
                end
            end
            FUNC_FIND_LONG, FUNC_FIND_SHORT: begin
                if (hit >= 0) r = entry_reply(hit, EVENT_NONE);
            end
            default: ;
        endcase
        r.fill = node_count[FILL_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Random operations: mostly keys already in the table, so hits, updates,
    // removals and the full table are all reached; 'grow' biases toward upserts
    // ------------------------------------------------------------------------
    function automatic op_t draw_registry_op(input bit grow);
        op_t op;
        int  pick;
        int  idx;
        bit  reuse;
        op.long_addr = {$urandom, $urandom};
        op.net_addr  = SHORT_W'($urandom);
        op.beat_seq  = $urandom;
        pick = $urandom_range(0, 99);
        if (grow) begin
            if (pick < 45)      op.func = FUNC_UPSERT;
            else if (pick < 55) op.func = FUNC_REMOVE;
            else if (pick < 70) op.func = FUNC_HEARTBEAT;
            else if (pick < 82) op.func = FUNC_FIND_LONG;
            else if (pick < 94) op.func = FUNC_FIND_SHORT;
            else                op.func = FUNC_W'($urandom_range(FUNC_RSVD_LO, FUNC_RSVD_HI));
        end else begin
            if (pick < 15)      op.func = FUNC_UPSERT;
            else if (pick < 50) op.func = FUNC_REMOVE;
            else if (pick < 68) op.func = FUNC_HEARTBEAT;
            else if (pick < 81) op.func = FUNC_FIND_LONG;
            else if (pick < 95) op.func = FUNC_FIND_SHORT;
            else                op.func = FUNC_W'($urandom_range(FUNC_RSVD_LO, FUNC_RSVD_HI));
        end
        // upserts bring a fresh key about half the time; everything else mostly hits
        reuse = (op.func == FUNC_UPSERT) ? ($urandom_range(0, 1) == 0)
                                         : ($urandom_range(0, 4) != 0);
        if (node_count > 0) begin
            idx = $urandom_range(0, node_count - 1);
            if (reuse) begin
                op.long_addr = node_long[idx];
                if (op.func != FUNC_UPSERT) op.net_addr = node_short[idx];
            end else if (op.func == FUNC_UPSERT && $urandom_range(0, 7) == 0) begin
                op.net_addr = node_short[idx];      // duplicate short address
            end
        end
        // occasional extremes
        if ($urandom_range(0, 15) == 0) op.long_addr = $urandom_range(0, 1) ? '1 : '0;
        if ($urandom_range(0, 15) == 0) op.net_addr  = $urandom_range(0, 1) ? '1 : '0;
        if ($urandom_range(0, 15) == 0) op.beat_seq  = $urandom_range(0, 1) ? '1 : '0;
        return op;
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // offer one operation and wait for its transfer; the owed result is the
    // typed one for typed rows, otherwise the predictor's
    task automatic offer_op(input op_t op, input logic typed, input reply_t want);
        reply_t predicted;
        s_tvalid <= 1'b1;
        s_tdata  <= {op.beat_seq, op.net_addr, op.long_addr};
        s_tuser  <= op.func;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = apply_registry_op(op);
        queued_replies.push_back(typed ? want : predicted);
    endtask

    // bursts of random length, random gaps between them; some bursts are
    // followed directly by the next, giving long stretches with no idling
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
    endtask

    function automatic row_t mk_row(input logic [FUNC_W-1:0] func,
                                    input logic [LONG_W-1:0] l,
                                    input logic [SHORT_W-1:0] s,
                                    input logic [SEQ_W-1:0] sq,
                                    input logic typed,
                                    input reply_t want);
        row_t row;
        row.op.func      = func;
        row.op.long_addr = l;
        row.op.net_addr  = s;
        row.op.beat_seq  = sq;
        row.typed        = typed;
        row.want         = want;
        return row;
    endfunction

    initial begin : stimulus
        row_t   rows[$];
        reply_t miss0;
        reply_t none;
        op_t    op;
        bit     grow;
        int     phase_left;
        logic [LONG_W-1:0]  l;
        logic [SHORT_W-1:0] s;

        miss0 = mk_reply(STATUS_NOT_FOUND, EVENT_NONE, '0, '0, 1'b0, '0, 5'd0);
        none  = '0;

        // --- directed table -------------------------------------------------
        // empty table: every search misses, unused codes miss too
        rows.push_back(mk_row(FUNC_FIND_LONG, '0, '0, '0, 1'b1, miss0));
        rows.push_back(mk_row(FUNC_REMOVE, '0, '1, '0, 1'b1, miss0));
        rows.push_back(mk_row(FUNC_HEARTBEAT, '1, '0, '1, 1'b1, miss0));
        rows.push_back(mk_row(FUNC_RSVD_LO, '1, '1, '1, 1'b1, miss0));
        rows.push_back(mk_row(FUNC_RSVD_HI, '0, '0, '0, 1'b1, miss0));
        // first entries at the extremes of the key and short address
        rows.push_back(mk_row(FUNC_UPSERT, '0, '0, '1, 1'b1,
                       mk_reply(STATUS_OK, EVENT_ONLINE, '0, '0, 1'b1, '0, 5'd1)));
        rows.push_back(mk_row(FUNC_UPSERT, '1, '1, '1, 1'b1,
                       mk_reply(STATUS_OK, EVENT_ONLINE, '1, '1, 1'b1, '0, 5'd2)));
        // fill the rest of the table; entry 5 repeats short address zero
        for (int k = 2; k < ENTRIES; k++) begin
            l = (k == 8) ? 64'h8000_0000_0000_0000 : 64'h0123_4567_89AB_0000 + LONG_W'(k);
            s = (k == 5) ? 16'h0000 : SHORT_W'(16'h0100 * k);
            rows.push_back(mk_row(FUNC_UPSERT, l, s, '0, 1'b0, none));
        end
        // full table refuses a new key
        rows.push_back(mk_row(FUNC_UPSERT, 64'h5A5A_5A5A_5A5A_5A5A, 16'h1234, '0, 1'b1,
                       mk_reply(STATUS_FULL, EVENT_NONE, '0, '0, 1'b0, '0, 5'd16)));
        // heartbeat, then upsert of the same known key clears the sequence
        rows.push_back(mk_row(FUNC_HEARTBEAT, '1, '0, '1, 1'b0, none));
        rows.push_back(mk_row(FUNC_UPSERT, '1, 16'h8001, '0, 1'b0, none));
        rows.push_back(mk_row(FUNC_FIND_SHORT, '0, 16'h8001, '0, 1'b0, none));
        rows.push_back(mk_row(FUNC_FIND_LONG, 64'h8000_0000_0000_0000, '0, '0, 1'b0, none));
        // remove entry 0 (last moves into the hole), then look up the duplicate
        rows.push_back(mk_row(FUNC_REMOVE, '0, 16'h0000, '0, 1'b0, none));
        rows.push_back(mk_row(FUNC_FIND_SHORT, '0, 16'h0000, '0, 1'b0, none));
        // remove the last entry: no move needed
        rows.push_back(mk_row(FUNC_REMOVE, '0, 16'h0E00, '0, 1'b0, none));
        rows.push_back(mk_row(FUNC_RSVD_MID, '1, '1, '1, 1'b1,
                       mk_reply(STATUS_NOT_FOUND, EVENT_NONE, '0, '0, 1'b0, '0, 5'd14)));

        // reset once, synchronous
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        burst_left = $urandom_range(1, 40);
        foreach (rows[i]) begin
            offer_op(rows[i].op, rows[i].typed, rows[i].want);
            pace_sender();
        end

        // --- random part ----------------------------------------------------
        grow       = 1'b1;
        phase_left = $urandom_range(60, 160);
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (phase_left == 0) begin
                grow       = ~grow;
                phase_left = $urandom_range(60, 160);
            end
            phase_left--;
            // long sink hold-off while we keep offering: the block backs up
            if (n == 300 || n == 950) hold_req <= 1'b1;
            // sender pauses until every owed result has come back
            if (n == 620) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (queued_replies.size() != 0) @(posedge aclk);
            end
            op = draw_registry_op(grow);
            offer_op(op, 1'b0, none);
            pace_sender();
        end
        s_tvalid <= 1'b0;

        // drain, then a short tail to catch any stray result transfer
        while (queued_replies.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_cnt == 0 && queued_replies.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver side: pattern changes at random intervals; a hold request
    // from the sender forces m_tready low until the hold-off counter runs out,
    // counted here
    initial begin : sink_side
        sink_mode_t mode;
        int         mode_left;
        int         hold_left;
        mode      = SINK_OPEN;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req  <= 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = sink_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(32, 256);
                end
                mode_left--;
                case (mode)
                    SINK_OPEN:       m_tready <= 1'b1;
                    SINK_COIN:       m_tready <= 1'($urandom_range(0, 1));
                    SINK_THIRD:      m_tready <= (cycle_cnt % 3 == 0);
                    SINK_RARE_STALL: m_tready <= ($urandom_range(0, 7) != 0);
                    default:         m_tready <= 1'b1;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result check: each result transfer against the oldest owed result
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : reply_check
        reply_t got;
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser[1:0], m_tuser[3:2], m_tdata[63:0], m_tdata[79:64], m_tdata[80],
                   m_tdata[112:81], m_tdata[117:113], m_tdata[119:118]};
            if (queued_replies.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result transfer: st=%0d ev=%0d long=%h short=%h",
                             got.status, got.kind, got.entry_long, got.entry_short);
            end else begin
                want = queued_replies.pop_front();
                if (got !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("result mismatch: want st=%0d ev=%0d long=%h short=%h on=%0d",
                                 want.status, want.kind, want.entry_long, want.entry_short,
                                 want.entry_online);
                        $display("    seq=%h fill=%0d pad=%0d", want.entry_seq, want.fill,
                                 want.pad);
                        $display("  got  st=%0d ev=%0d long=%h short=%h on=%0d",
                                 got.status, got.kind, got.entry_long, got.entry_short,
                                 got.entry_online);
                        $display("    seq=%h fill=%0d pad=%0d", got.entry_seq, got.fill,
                                 got.pad);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
